@@ rtl/gdsf_pkg.sv @@
// Package for the GDSF cache policy block: field widths, the slot entry type,
// the controller state type and register codes. No dependencies.
package gdsf_pkg;

  localparam int unsigned KeyW         = 32;
  localparam int unsigned SizeW        = 32;
  localparam int unsigned HitsW        = 32;
  localparam int unsigned PrioW        = 64;
  localparam int unsigned CntW         = 32;
  localparam int unsigned EvcW         = 7;
  localparam int unsigned DefaultSlots = 64;
  localparam int unsigned DivSteps     = 64;
  localparam int unsigned DivCntW      = 6;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;

  localparam logic [SizeW-1:0] CapReset = 32'h0010_0000;
  localparam logic             CmdClear = 1'b1;
  localparam logic             RegCap   = 1'b0;  // register index bit paddr[2]

  // one slot of the policy table
  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [SizeW-1:0] size;
    logic [HitsW-1:0] hits;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DIVGO,
    S_DIV,
    S_WRITE,
    S_DONE
  } state_e;

endpackage

@@ rtl/gdsf_if.sv @@
// Request and response channel interfaces of the GDSF cache policy block.
// Depends on gdsf_pkg for field widths.
interface gdsf_req_if;
  import gdsf_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KeyW-1:0]  object_key;
  logic [SizeW-1:0] object_size;

  modport source (output valid, cmd, object_key, object_size, input ready);
  modport sink   (input valid, cmd, object_key, object_size, output ready);
endinterface

interface gdsf_rsp_if;
  import gdsf_pkg::*;
  logic            valid;
  logic            ready;
  logic            hit;
  logic            resident;
  logic [EvcW-1:0] evicted_count;
  logic [CntW-1:0] hit_total;
  logic [CntW-1:0] request_total;

  modport source (output valid, hit, resident, evicted_count, hit_total, request_total,
                  input ready);
  modport sink   (input valid, hit, resident, evicted_count, hit_total, request_total,
                  output ready);
endinterface

@@ rtl/gdsf_cache_policy.sv @@
// GDSF cache policy: a request takes one table rotation of SLOTS slots, plus one
// rotation per eviction, plus for a hit or an insert a divide and a write rotation.
// One request at a time. Reset empties all slots at once (valid bits) and zeroes
// inflation, bytes and totals; capacity resets to 1 MiB.
module gdsf_cache_policy import gdsf_pkg::*; #(
  parameter int unsigned SLOTS = DefaultSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gdsf_req_if.sink            req_i,
  gdsf_rsp_if.source          rsp_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output logic [ApbDataW-1:0] prdata_o,
  output logic                pready_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);

  state_e state_q, state_d;

  entry_t ring [SLOTS];
  entry_t cur, wr_ent_q, wr_ent_d;
  logic   shift, clr;

  logic [SizeW-1:0] cap_q;
  logic [PrioW-1:0] infl_q, infl_d;
  logic [SizeW-1:0] used_q, used_d;
  logic [CntW-1:0]  hit_cnt_q, hit_cnt_d, req_cnt_q, req_cnt_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic             kill_q, kill_d;
  logic [IdxW-1:0]  kill_idx_q, kill_idx_d, wr_idx_q, wr_idx_d;
  logic             rsp_valid_q, rsp_valid_d;

  logic [KeyW-1:0]  key_q, key_d;
  logic [SizeW-1:0] size_q, size_d;
  logic             clr_op_q, clr_op_d, first_q, first_d;
  logic             hit_q, hit_d, res_q, res_d;
  logic [EvcW-1:0]  evc_q, evc_d;
  logic [HitsW-1:0] num_q, num_d;
  logic [SizeW-1:0] den_q, den_d;

  // pass statistics
  logic             mt_f_q, mt_f_d, fr_f_q, fr_f_d, mn_f_q, mn_f_d;
  logic [IdxW-1:0]  mt_idx_q, mt_idx_d, fr_idx_q, fr_idx_d, mn_idx_q, mn_idx_d;
  logic [HitsW-1:0] mt_hits_q, mt_hits_d;
  logic [SizeW-1:0] mt_size_q, mt_size_d, mn_size_q, mn_size_d;
  logic [PrioW-1:0] mn_prio_q, mn_prio_d;

  logic             rsp_hit_q, rsp_res_q, rsp_hit_d, rsp_res_d;
  logic [EvcW-1:0]  rsp_evc_q, rsp_evc_d;
  logic [CntW-1:0]  rsp_hits_q, rsp_reqs_q, rsp_hits_d, rsp_reqs_d;

  logic             div_start, div_done;
  logic [PrioW-1:0] quo;
  logic [PrioW:0]   psum;
  logic [SizeW:0]   need_bytes;
  logic             fits, last;
  logic [HitsW-1:0] hits_inc;
  logic             cfg_wr;

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign prdata_o = (paddr_i[2] == RegCap) ? cap_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_wr && paddr_i[2] == RegCap) begin
      cap_q <= pwdata_i;
    end
  end

  // cell row; the head feeds back to the tail through the update logic
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    entry_t nxt;
    if (g == SLOTS - 1) begin : g_tail
      assign nxt = cur;
    end else begin : g_mid
      assign nxt = ring[g+1];
    end
    gdsf_cell u_cell (
      .clk_i,
      .rst_ni,
      .shift_i (shift),
      .clr_i   (clr),
      .ent_i   (nxt),
      .ent_o   (ring[g])
    );
  end

  gdsf_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign shift      = (state_q == S_SCAN) || (state_q == S_WRITE);
  assign clr        = (state_q == S_IDLE) && req_i.valid && (req_i.cmd == CmdClear);
  assign div_start  = (state_q == S_DIVGO);
  assign last       = pos_q == IdxW'(SLOTS - 1);
  assign psum       = {1'b0, infl_q} + {1'b0, quo};
  assign need_bytes = {1'b0, used_q} + {1'b0, size_q};
  assign fits       = need_bytes <= {1'b0, cap_q};
  assign hits_inc   = (mt_hits_q == '1) ? mt_hits_q : mt_hits_q + 1'b1;
  assign req_i.ready = (state_q == S_IDLE);

  // head entry with a pending eviction or write applied
  always_comb begin
    cur = ring[0];
    if (kill_q && pos_q == kill_idx_q) cur.valid = 1'b0;
    if (state_q == S_WRITE && pos_q == wr_idx_q) cur = wr_ent_q;
  end

  // next state and datapath
  always_comb begin
    state_d    = state_q;
    infl_d     = infl_q;
    used_d     = used_q;
    hit_cnt_d  = hit_cnt_q;
    req_cnt_d  = req_cnt_q;
    pos_d      = pos_q;
    kill_d     = kill_q;
    kill_idx_d = kill_idx_q;
    wr_idx_d   = wr_idx_q;
    wr_ent_d   = wr_ent_q;
    rsp_valid_d = rsp_valid_q;
    key_d      = key_q;
    size_d     = size_q;
    clr_op_d   = clr_op_q;
    first_d    = first_q;
    hit_d      = hit_q;
    res_d      = res_q;
    evc_d      = evc_q;
    num_d      = num_q;
    den_d      = den_q;
    mt_f_d     = mt_f_q;
    fr_f_d     = fr_f_q;
    mn_f_d     = mn_f_q;
    mt_idx_d   = mt_idx_q;
    fr_idx_d   = fr_idx_q;
    mn_idx_d   = mn_idx_q;
    mt_hits_d  = mt_hits_q;
    mt_size_d  = mt_size_q;
    mn_size_d  = mn_size_q;
    mn_prio_d  = mn_prio_q;
    rsp_hit_d  = rsp_hit_q;
    rsp_res_d  = rsp_res_q;
    rsp_evc_d  = rsp_evc_q;
    rsp_hits_d = rsp_hits_q;
    rsp_reqs_d = rsp_reqs_q;

    if (rsp_o.ready) rsp_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d    = req_i.object_key;
          size_d   = (req_i.object_size == '0) ? SizeW'(1) : req_i.object_size;
          clr_op_d = (req_i.cmd == CmdClear);
          hit_d    = 1'b0;
          res_d    = 1'b0;
          evc_d    = '0;
          first_d  = 1'b1;
          pos_d    = '0;
          mt_f_d   = 1'b0;
          fr_f_d   = 1'b0;
          mn_f_d   = 1'b0;
          if (req_i.cmd == CmdClear) begin
            infl_d  = '0;
            used_d  = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!mt_f_q && cur.valid && cur.key == key_q) begin
          mt_f_d    = 1'b1;
          mt_idx_d  = pos_q;
          mt_hits_d = cur.hits;
          mt_size_d = cur.size;
        end
        if (!fr_f_q && !cur.valid) begin
          fr_f_d   = 1'b1;
          fr_idx_d = pos_q;
        end
        if (cur.valid && (!mn_f_q || cur.prio < mn_prio_q)) begin
          mn_f_d    = 1'b1;
          mn_idx_d  = pos_q;
          mn_prio_d = cur.prio;
          mn_size_d = cur.size;
        end
        pos_d = pos_q + 1'b1;
        if (last) begin
          pos_d   = '0;
          kill_d  = 1'b0;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (first_q && mt_f_q) begin
          // hit: bump count, reprice
          hit_d    = 1'b1;
          res_d    = 1'b1;
          wr_idx_d = mt_idx_q;
          wr_ent_d = '{valid: 1'b1, key: key_q, size: mt_size_q, hits: hits_inc, prio: '0};
          num_d    = hits_inc;
          den_d    = mt_size_q;
          state_d  = S_DIVGO;
        end else if (size_q > cap_q) begin
          state_d = S_DONE;
        end else if ((!fits || !fr_f_q) && mn_f_q) begin
          // evict the minimum and rescan
          used_d     = used_q - ((mn_size_q <= used_q) ? mn_size_q : used_q);
          infl_d     = mn_prio_q;
          kill_d     = 1'b1;
          kill_idx_d = mn_idx_q;
          evc_d      = (evc_q == '1) ? evc_q : evc_q + 1'b1;
          first_d    = 1'b0;
          mt_f_d     = 1'b0;
          fr_f_d     = 1'b0;
          mn_f_d     = 1'b0;
          state_d    = S_SCAN;
        end else if (fr_f_q && fits) begin
          // insert into lowest free slot
          res_d    = 1'b1;
          used_d   = need_bytes[SizeW-1:0];
          wr_idx_d = fr_idx_q;
          wr_ent_d = '{valid: 1'b1, key: key_q, size: size_q, hits: HitsW'(1), prio: '0};
          num_d    = HitsW'(1);
          den_d    = size_q;
          state_d  = S_DIVGO;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIVGO: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          wr_ent_d.prio = psum[PrioW] ? '1 : psum[PrioW-1:0];
          pos_d         = '0;
          state_d       = S_WRITE;
        end
      end
      S_WRITE: begin
        pos_d = pos_q + 1'b1;
        if (last) begin
          pos_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          hit_cnt_d   = hit_cnt_q + CntW'(hit_q);
          req_cnt_d   = req_cnt_q + CntW'(!clr_op_q);
          rsp_hit_d   = hit_q;
          rsp_res_d   = res_q;
          rsp_evc_d   = evc_q;
          rsp_hits_d  = hit_cnt_d;
          rsp_reqs_d  = req_cnt_d;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      infl_q      <= '0;
      used_q      <= '0;
      hit_cnt_q   <= '0;
      req_cnt_q   <= '0;
      pos_q       <= '0;
      kill_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      infl_q      <= infl_d;
      used_q      <= used_d;
      hit_cnt_q   <= hit_cnt_d;
      req_cnt_q   <= req_cnt_d;
      pos_q       <= pos_d;
      kill_q      <= kill_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kill_idx_q <= kill_idx_d;
    wr_idx_q   <= wr_idx_d;
    wr_ent_q   <= wr_ent_d;
    key_q      <= key_d;
    size_q     <= size_d;
    clr_op_q   <= clr_op_d;
    first_q    <= first_d;
    hit_q      <= hit_d;
    res_q      <= res_d;
    evc_q      <= evc_d;
    num_q      <= num_d;
    den_q      <= den_d;
    mt_f_q     <= mt_f_d;
    fr_f_q     <= fr_f_d;
    mn_f_q     <= mn_f_d;
    mt_idx_q   <= mt_idx_d;
    fr_idx_q   <= fr_idx_d;
    mn_idx_q   <= mn_idx_d;
    mt_hits_q  <= mt_hits_d;
    mt_size_q  <= mt_size_d;
    mn_size_q  <= mn_size_d;
    mn_prio_q  <= mn_prio_d;
    rsp_hit_q  <= rsp_hit_d;
    rsp_res_q  <= rsp_res_d;
    rsp_evc_q  <= rsp_evc_d;
    rsp_hits_q <= rsp_hits_d;
    rsp_reqs_q <= rsp_reqs_d;
  end

  // response register
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = rsp_hit_q;
  assign rsp_o.resident      = rsp_res_q;
  assign rsp_o.evicted_count = rsp_evc_q;
  assign rsp_o.hit_total     = rsp_hits_q;
  assign rsp_o.request_total = rsp_reqs_q;

`ifndef SYNTH
  a_clear_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (used_q == '0) && (infl_q == '0))
    else $error("clear did not zero bytes and inflation");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && hit_q |-> (evc_q == '0) && res_q)
    else $error("hit with evictions or not resident");

  a_pass_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) || (state_q == S_IDLE) |-> (pos_q == '0))
    else $error("table rotation left misaligned");
`endif

endmodule

@@ rtl/gdsf_cell.sv @@
// One slot cell of the rotating policy table; passes its entry to the next
// cell on every shift. Depends on gdsf_pkg.
module gdsf_cell import gdsf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  logic   clr_i,
  input  entry_t ent_i,
  output entry_t ent_o
);

  logic             valid_q;
  logic [KeyW-1:0]  key_q;
  logic [SizeW-1:0] size_q;
  logic [HitsW-1:0] hits_q;
  logic [PrioW-1:0] prio_q;

  // valid bit: cleared by reset and by a clear command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= ent_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q  <= ent_i.key;
      size_q <= ent_i.size;
      hits_q <= ent_i.hits;
      prio_q <= ent_i.prio;
    end
  end

  assign ent_o = '{valid: valid_q, key: key_q, size: size_q, hits: hits_q, prio: prio_q};

endmodule

@@ rtl/gdsf_div.sv @@
// Restoring divider for (num << 32) / den, one quotient bit per cycle.
// Depends on gdsf_pkg.
module gdsf_div import gdsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [HitsW-1:0] num_i,
  input  logic [SizeW-1:0] den_i,
  output logic             done_o,
  output logic [PrioW-1:0] quo_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [SizeW-1:0]   rem_q, den_q;
  logic [PrioW-1:0]   dvd_q;
  logic [SizeW:0]     trial, diff;
  logic               ge;

  // trial subtract of the next dividend bit
  assign trial = {rem_q, dvd_q[PrioW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= {num_i, {SizeW{1'b0}}};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SizeW-1:0] : trial[SizeW-1:0];
      dvd_q <= {dvd_q[PrioW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

@@ verif/gdsf_cache_policy_tb.sv @@
// Testbench for gdsf_cache_policy: directed table then random request traffic, with
// a GDSF table predictor, random request gaps and response stalls, APB capacity writes.
// Depends on gdsf_pkg, gdsf_req_if / gdsf_rsp_if and the gdsf_cache_policy RTL.
`timescale 1ns / 100ps

module gdsf_cache_policy_tb;
  import gdsf_pkg::*;

  localparam int NumSlots = 64;
  localparam int CycleLimit = 3000000;
  localparam logic [ApbAddrW-1:0] CapAddr = {RegCap, 2'b00};

  typedef struct packed {
    logic            hit;
    logic            resident;
    logic [EvcW-1:0] evicted;
    logic [CntW-1:0] hits_seen;
    logic [CntW-1:0] reqs_seen;
  } outcome_t;

  typedef struct packed {
    logic             cmd;
    logic [KeyW-1:0]  key;
    logic [SizeW-1:0] size;
    logic             typed;
    outcome_t         outcome;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel_i = 1'b0, penable_i = 1'b0, pwrite_i = 1'b0;
  logic [ApbAddrW-1:0] paddr_i = '0;
  logic [ApbDataW-1:0] pwdata_i = '0;
  logic [ApbDataW-1:0] prdata_o;
  logic pready_o;

  gdsf_req_if req_bus ();
  gdsf_rsp_if rsp_bus ();

  gdsf_cache_policy dut (
    .clk_i, .rst_ni, .req_i(req_bus), .rsp_o(rsp_bus),
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the policy table
  logic             slot_on   [NumSlots];
  logic [KeyW-1:0]  slot_key  [NumSlots];
  logic [SizeW-1:0] slot_size [NumSlots];
  logic [HitsW-1:0] slot_hits [NumSlots];
  logic [PrioW-1:0] slot_prio [NumSlots];
  logic [PrioW-1:0] inflation;
  logic [SizeW-1:0] used_bytes, capacity;
  logic [CntW-1:0]  hit_count, req_count;

  outcome_t pending_outcomes[$];
  bit failed = 0;
  int burst_left = 0;

  function automatic logic [PrioW-1:0] gdsf_rank(logic [HitsW-1:0] hits,
                                                 logic [SizeW-1:0] size);
    logic [PrioW-1:0] quo, sum;
    quo = {hits, 32'h0} / {32'h0, (size == 0) ? 32'd1 : size};
    sum = inflation + quo;
    return (sum < inflation) ? '1 : sum;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < NumSlots; i++) if (!slot_on[i]) return i;
    return -1;
  endfunction

  // one request or clear applied to the predictor table
  function automatic outcome_t gdsf_apply(logic cmd, logic [KeyW-1:0] key,
                                          logic [SizeW-1:0] size);
    outcome_t o;
    int found, victim, spot, evc;
    o = '0;
    found = -1;
    evc = 0;
    if (cmd == CmdClear) begin
      foreach (slot_on[i]) slot_on[i] = 1'b0;
      inflation = '0;
      used_bytes = '0;
    end else begin
      if (size == 0) size = 1;
      for (int i = 0; i < NumSlots; i++)
        if (found < 0 && slot_on[i] && slot_key[i] == key) found = i;
      if (found >= 0) begin
        if (slot_hits[found] != '1) slot_hits[found]++;
        slot_prio[found] = gdsf_rank(slot_hits[found], slot_size[found]);
        o.hit = 1'b1;
        o.resident = 1'b1;
        hit_count++;
      end else if (size <= capacity) begin
        // evict lowest priority (lowest index on ties) until bytes and a slot fit
        while ({32'h0, used_bytes} + size > {32'h0, capacity} || first_free() < 0) begin
          victim = -1;
          for (int i = 0; i < NumSlots; i++)
            if (slot_on[i] && (victim < 0 || slot_prio[i] < slot_prio[victim])) victim = i;
          if (victim < 0) break;
          slot_on[victim] = 1'b0;
          used_bytes -= (slot_size[victim] <= used_bytes) ? slot_size[victim] : used_bytes;
          inflation = slot_prio[victim];
          evc++;
        end
        spot = first_free();
        if (spot >= 0 && {32'h0, used_bytes} + size <= {32'h0, capacity}) begin
          slot_on[spot] = 1'b1;
          slot_key[spot] = key;
          slot_size[spot] = size;
          slot_hits[spot] = 1;
          slot_prio[spot] = gdsf_rank(1, size);
          used_bytes += size;
          o.resident = 1'b1;
        end
      end
      req_count++;
    end
    o.evicted = (evc > 127) ? 7'd127 : evc[EvcW-1:0];
    o.hits_seen = hit_count;
    o.reqs_seen = req_count;
    return o;
  endfunction

  // send one request in bursts with random gaps; predict at the transfer
  task automatic send_request(logic cmd, logic [KeyW-1:0] key, logic [SizeW-1:0] size,
                              logic typed, outcome_t typed_outcome);
    outcome_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_bus.valid <= 1'b1;
    req_bus.cmd <= cmd;
    req_bus.object_key <= key;
    req_bus.object_size <= size;
    do @(posedge clk_i); while (!req_bus.ready);
    predicted = gdsf_apply(cmd, key, size);
    pending_outcomes.push_back(typed ? typed_outcome : predicted);
  endtask

  // idle the request side until every expected response has come back
  task automatic drain();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // capacity write then read-back, two-phase APB
  task automatic set_capacity(logic [SizeW-1:0] value);
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= CapAddr; pwdata_i <= value;
    @(posedge clk_i) penable_i <= 1'b1;
    @(posedge clk_i) begin
      psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b0;
    end
    capacity = value;
    @(posedge clk_i) penable_i <= 1'b1;
    @(posedge clk_i) begin
      if (prdata_o !== value) begin
        $display("%0t capacity read-back: expected %h actual %h", $time, value, prdata_o);
        failed = 1;
      end
      psel_i <= 1'b0; penable_i <= 1'b0;
    end
  endtask

  // response stalls: no stalls, random, or periodic, switching mode in turn
  int stall_cycle = 0;
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 256) % 3)
      0: rsp_bus.ready <= 1'b1;
      1: rsp_bus.ready <= ($urandom_range(0, 99) >= 35);
      default: rsp_bus.ready <= (stall_cycle % 7) < 4;
    endcase
  end

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t response with none expected", $time);
        failed = 1;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_bus.hit !== want.hit) begin
          $display("%0t hit: expected %0d actual %0d", $time, want.hit, rsp_bus.hit);
          failed = 1;
        end
        if (rsp_bus.resident !== want.resident) begin
          $display("%0t resident: expected %0d actual %0d", $time, want.resident,
                   rsp_bus.resident);
          failed = 1;
        end
        if (rsp_bus.evicted_count !== want.evicted) begin
          $display("%0t evicted_count: expected %0d actual %0d", $time, want.evicted,
                   rsp_bus.evicted_count);
          failed = 1;
        end
        if (rsp_bus.hit_total !== want.hits_seen) begin
          $display("%0t hit_total: expected %0d actual %0d", $time, want.hits_seen,
                   rsp_bus.hit_total);
          failed = 1;
        end
        if (rsp_bus.request_total !== want.reqs_seen) begin
          $display("%0t request_total: expected %0d actual %0d", $time, want.reqs_seen,
                   rsp_bus.request_total);
          failed = 1;
        end
      end
    end
  end

  // run limit
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t plan[$];
    logic [SizeW-1:0] caps[6];
    logic [KeyW-1:0] key;
    logic [SizeW-1:0] size;
    int pick;
    req_bus.valid = 1'b0;
    req_bus.cmd = 1'b0;
    req_bus.object_key = '0;
    req_bus.object_size = '0;
    rsp_bus.ready = 1'b0;
    foreach (slot_on[i]) slot_on[i] = 1'b0;
    inflation = '0; used_bytes = '0; hit_count = '0; req_count = '0;
    capacity = CapReset;

    // directed rows: cmd, key, size, typed, expected {hit, resident, evicted, hits, reqs}
    plan.push_back({1'b0, 32'd5, 32'd0, 1'b1, {1'b0, 1'b1, 7'd0, 32'd0, 32'd1}});
    plan.push_back({1'b0, 32'd5, 32'd99, 1'b1, {1'b1, 1'b1, 7'd0, 32'd1, 32'd2}});
    plan.push_back({1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                    {1'b0, 1'b0, 7'd0, 32'd1, 32'd3}});
    plan.push_back({1'b0, 32'd0, 32'h0010_0000, 1'b1, {1'b0, 1'b1, 7'd1, 32'd1, 32'd4}});
    plan.push_back({CmdClear, 32'd0, 32'd0, 1'b1, {1'b0, 1'b0, 7'd0, 32'd1, 32'd4}});
    plan.push_back({1'b0, 32'd0, 32'd1, 1'b1, {1'b0, 1'b1, 7'd0, 32'd1, 32'd5}});
    plan.push_back({1'b0, 32'd0, 32'd7, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd7, 32'd2, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd8, 32'd3, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd7, 32'd0, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd9, 32'h000F_FFFF, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd9, 32'd1, 1'b0, outcome_t'(0)});
    plan.push_back({CmdClear, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd12, 32'h0010_0001, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd13, 32'h0008_0000, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd14, 32'h0008_0000, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd15, 32'h0008_0000, 1'b0, outcome_t'(0)});
    plan.push_back({1'b0, 32'd13, 32'd5, 1'b0, outcome_t'(0)});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i])
      send_request(plan[i].cmd, plan[i].key, plan[i].size, plan[i].typed, plan[i].outcome);

    // random phases; the last one lowers capacity under the bytes in use
    caps = '{32'd200, 32'd1, 32'hFFFF_FFFF, 32'h0010_0000, 32'd5000, 32'd50};
    foreach (caps[p]) begin
      drain();
      set_capacity(caps[p]);
      for (int n = 0; n < 165; n++) begin
        // hold off the sender until the pipe is empty, once per phase
        if (n == 80) drain();
        pick = $urandom_range(0, 99);
        key = $urandom_range(0, 79);
        size = (caps[p] <= 1) ? $urandom_range(0, 1) :
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
        if (pick < 3) begin
          send_request(CmdClear, $urandom, $urandom, 1'b0, outcome_t'(0));
        end else if (pick < 13) begin
          send_request(1'b0, $urandom, $urandom, 1'b0, outcome_t'(0));
        end else begin
          send_request(1'b0, key, size, 1'b0, outcome_t'(0));
        end
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (!failed && pending_outcomes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
